// ----- design/speck_pkg.sv -----
// Shared constants and types for the SPECK-64/128 block cipher.
// No dependencies; used by the controller, the datapath and the top level.
package speck_pkg;

  localparam int WORD_W         = 32;
  localparam int ROUND_COUNT_DEF = 27;
  localparam int CFG_IDX_W      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 2'd3;

  // operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic kload;      // load schedule words from key registers
    logic exp_step;   // one key schedule step, write round key
    logic in_load;    // capture input block
    logic round_step; // one cipher round
    logic dec;        // round direction
    logic out_load;   // load output register
  } ctrl_cmd_t;

endpackage

// ----- design/speck_ctrl.sv -----
// Controller FSM for the SPECK-64/128 block cipher: sequencing, round counter,
// handshakes. Depends on speck_pkg.
module speck_ctrl #(
  parameter int ROUND_COUNT = speck_pkg::ROUND_COUNT_DEF,
  localparam int IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  output logic                  out_valid,
  input  logic                  out_ready,
  output speck_pkg::ctrl_cmd_t  cmd,
  output logic [IDX_W-1:0]      key_idx,
  output logic [IDX_W-1:0]      key_rd_idx
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_KLOAD  = 5'b00010,
    S_EXPAND = 5'b00100,
    S_RUN    = 5'b01000,
    S_HOLD   = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUND_COUNT - 1);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              dec_r, dec_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              run_last;
  logic              in_acc;

  assign out_free = !out_valid_r || out_ready;
  assign run_last = dec_r ? (cnt_r == '0) : (cnt_r == LAST_IDX);
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign key_idx  = cnt_r;
  // round key store is read with the next count, as its read is registered
  assign key_rd_idx = cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dec_nxt   = dec_r;
    cmd       = '0;
    cmd.dec   = dec_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.in_load = 1'b1;
          dec_nxt     = (in_operation == speck_pkg::OP_DECRYPT);
          cnt_nxt     = (in_operation == speck_pkg::OP_DECRYPT) ? LAST_IDX : '0;
          state_nxt   = S_RUN;
        end
      end
      S_KLOAD: begin
        cmd.kload = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_EXPAND;
      end
      S_EXPAND: begin
        cmd.exp_step = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RUN: begin
        cmd.round_step = 1'b1;
        if (run_last) begin
          cmd.out_load = out_free;
          state_nxt    = out_free ? S_IDLE : S_HOLD;
        end else begin
          cnt_nxt = dec_r ? (cnt_r - 1'b1) : (cnt_r + 1'b1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_KLOAD;
      end
    endcase
    // key write restarts the schedule
    if (cfg_we) begin
      state_nxt = S_KLOAD;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_KLOAD;
      cnt_r       <= '0;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dec_r       <= dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // accepted transaction always starts a run
  a_acc_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_we |=> state_r == S_RUN)
    else $error("accepted transaction did not start a run");

  // result waiting on a stalled receiver is kept
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("pending result dropped");

  // no result loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output register overwritten");

  // round counter stays in range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_IDX)
    else $error("round counter out of range");

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

endmodule

// ----- design/speck_dp.sv -----
// Datapath for the SPECK-64/128 block cipher: key registers, key schedule,
// round key store, ARX round unit and output register. Depends on speck_pkg.
module speck_dp #(
  parameter int ROUND_COUNT = speck_pkg::ROUND_COUNT_DEF,
  localparam int IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [speck_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [speck_pkg::WORD_W-1:0]        cfg_wdata,
  input  speck_pkg::ctrl_cmd_t                cmd,
  input  logic [IDX_W-1:0]                    key_idx,
  input  logic [IDX_W-1:0]                    key_rd_idx,
  input  logic [speck_pkg::WORD_W-1:0]        in_block_high,
  input  logic [speck_pkg::WORD_W-1:0]        in_block_low,
  output logic [speck_pkg::WORD_W-1:0]        out_result_high,
  output logic [speck_pkg::WORD_W-1:0]        out_result_low
);

  localparam int W = speck_pkg::WORD_W;

  function automatic logic [W-1:0] ror(input logic [W-1:0] v, input int n);
    ror = (v >> n) | (v << (W - n));
  endfunction

  function automatic logic [W-1:0] rol(input logic [W-1:0] v, input int n);
    rol = (v << n) | (v >> (W - n));
  endfunction

  logic [W-1:0] key0_r, key1_r, key2_r, key3_r;
  logic [W-1:0] a_r, l0_r, l1_r, l2_r;
  logic [W-1:0] l_new, a_new;
  logic [W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [W-1:0] rk_r;
  logic [W-1:0] res_high_r, res_low_r;
  logic [W-1:0] key_mem [ROUND_COUNT];

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        speck_pkg::CFG_KEY0: key0_r <= cfg_wdata;
        speck_pkg::CFG_KEY1: key1_r <= cfg_wdata;
        speck_pkg::CFG_KEY2: key2_r <= cfg_wdata;
        speck_pkg::CFG_KEY3: key3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // schedule: l words rotate through l0 so the i mod 3 pick is always l0
  assign l_new = (ror(l0_r, 8) + a_r) ^ W'(key_idx);
  assign a_new = rol(a_r, 3) ^ l_new;

  always_ff @(posedge clk) begin
    if (cmd.kload) begin
      a_r  <= key0_r;
      l0_r <= key1_r;
      l1_r <= key2_r;
      l2_r <= key3_r;
    end else if (cmd.exp_step) begin
      a_r  <= a_new;
      l0_r <= l1_r;
      l1_r <= l2_r;
      l2_r <= l_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_step) begin
      key_mem[key_idx] <= a_r;
    end
  end

  // registered read: the key for next cycle's round
  always_ff @(posedge clk) begin
    rk_r <= key_mem[key_rd_idx];
  end

  // one ARX round, either direction
  always_comb begin
    if (cmd.dec) begin
      y_nxt = ror(y_r ^ x_r, 3);
      x_nxt = rol((x_r ^ rk_r) - y_nxt, 8);
    end else begin
      x_nxt = (ror(x_r, 8) + y_r) ^ rk_r;
      y_nxt = rol(y_r, 3) ^ x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      y_r <= in_block_high;
      x_r <= in_block_low;
    end else if (cmd.round_step) begin
      y_r <= y_nxt;
      x_r <= x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_high_r <= cmd.round_step ? y_nxt : y_r;
      res_low_r  <= cmd.round_step ? x_nxt : x_r;
    end
  end

  assign out_result_high = res_high_r;
  assign out_result_low  = res_low_r;

endmodule

// ----- design/speck64_128_block_cipher_top.sv -----
// Top level of the SPECK-64/128 block cipher (ECB, one block per transaction).
// Depends on speck_pkg, speck_ctrl and speck_dp.
//
// Usage:
//  - Key: four 32-bit words written on cfg_we/cfg_index/cfg_wdata, one per
//    cycle, no wait. Each write restarts the key schedule: a load step, then
//    one expansion step per round key, during which in_ready is low.
//  - Reset: key words clear to zero and the all-zero key is expanded, so
//    in_ready stays low until that expansion is done after reset is released.
//  - Input: in_valid/in_ready; in_operation 0 encrypts, 1 decrypts the block
//    in_block_high (y) / in_block_low (x).
//  - Rounds: one ARX round per clock through a single round unit against the
//    round key store.
//  - Blocks: one at a time; the next block is taken in the cycle after a
//    result is registered.
//  - Stall: the output register holds a result while out_ready is low; the
//    next block may run meanwhile and then waits in its working registers
//    until the output register is free.
module speck64_128_block_cipher_top #(
  parameter int ROUND_COUNT = speck_pkg::ROUND_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [speck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [speck_pkg::WORD_W-1:0]     cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [speck_pkg::WORD_W-1:0]     in_block_high,
  input  logic [speck_pkg::WORD_W-1:0]     in_block_low,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [speck_pkg::WORD_W-1:0]     out_result_high,
  output logic [speck_pkg::WORD_W-1:0]     out_result_low
);

  localparam int IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  speck_pkg::ctrl_cmd_t cmd;
  logic [IDX_W-1:0]     key_idx;
  logic [IDX_W-1:0]     key_rd_idx;

  // sequencing, round counter and handshakes
  speck_ctrl #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .key_idx      (key_idx),
    .key_rd_idx   (key_rd_idx)
  );

  // key schedule, round key store, round unit, output register
  speck_dp #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .key_idx         (key_idx),
    .key_rd_idx      (key_rd_idx),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .out_result_high (out_result_high),
    .out_result_low  (out_result_low)
  );

endmodule

// ----- bench/speck64_128_block_cipher_top_tb.sv -----
// Testbench for speck64_128_block_cipher_top: a SPECK-64/128 key schedule and
// round model predicts every block; a small scoreboard checks the results in order.
// Depends on speck_pkg and the block's top level only.
`timescale 1ns / 1ps

module speck64_128_block_cipher_top_tb;

  localparam int ROUNDS = speck_pkg::ROUND_COUNT_DEF;
  localparam int PHASE_BLOCKS = 195;   // random transactions per key setting
  localparam int PHASES = 7;
  localparam int MAX_PRINTED = 100;    // mismatch lines printed before going quiet

  // One accepted transaction together with the block we expect back for it.
  typedef struct {
    logic        op;
    logic [31:0] in_hi;
    logic [31:0] in_lo;
    logic [31:0] res_hi;
    logic [31:0] res_lo;
  } cipher_txn_t;

  // Scoreboard: own copy of the key words and round keys, plus the FIFO of
  // expected blocks. note_block() runs at input acceptance, check_block() at
  // output acceptance.
  class cipher_scoreboard;
    logic [31:0] key_words [4];
    logic [31:0] sched_keys [ROUNDS];
    cipher_txn_t expected_blocks [$];
    int          mismatches;

    function new();
      mismatches = 0;
      foreach (key_words[k]) key_words[k] = '0;
      expand_schedule();
    endfunction

    function logic [31:0] ror8(logic [31:0] v);
      return {v[7:0], v[31:8]};
    endfunction

    function logic [31:0] rol8(logic [31:0] v);
      return {v[23:0], v[31:24]};
    endfunction

    function logic [31:0] ror3(logic [31:0] v);
      return {v[2:0], v[31:3]};
    endfunction

    function logic [31:0] rol3(logic [31:0] v);
      return {v[28:0], v[31:29]};
    endfunction

    // a walks the round keys; l[] are the three schedule words, used in turn
    function void expand_schedule();
      logic [31:0] a;
      logic [31:0] l [3];
      int          j;
      a    = key_words[0];
      l[0] = key_words[1];
      l[1] = key_words[2];
      l[2] = key_words[3];
      for (int i = 0; i < ROUNDS; i++) begin
        j             = i % 3;
        sched_keys[i] = a;
        l[j]          = (ror8(l[j]) + a) ^ 32'(i);
        a             = rol3(a) ^ l[j];
      end
    endfunction

    // every key write re-expands the whole schedule
    function void set_key_word(logic [speck_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        speck_pkg::CFG_KEY0: key_words[0] = val;
        speck_pkg::CFG_KEY1: key_words[1] = val;
        speck_pkg::CFG_KEY2: key_words[2] = val;
        speck_pkg::CFG_KEY3: key_words[3] = val;
        default: return;
      endcase
      expand_schedule();
    endfunction

    function void cipher_block(input logic op, input logic [31:0] hi, input logic [31:0] lo,
                               output logic [31:0] res_hi, output logic [31:0] res_lo);
      logic [31:0] x;
      logic [31:0] y;
      y = hi;
      x = lo;
      if (op == speck_pkg::OP_ENCRYPT) begin
        for (int r = 0; r < ROUNDS; r++) begin
          x = (ror8(x) + y) ^ sched_keys[r];
          y = rol3(y) ^ x;
        end
      end else begin
        for (int r = ROUNDS - 1; r >= 0; r--) begin
          y = ror3(y ^ x);
          x = rol8((x ^ sched_keys[r]) - y);
        end
      end
      res_hi = y;
      res_lo = x;
    endfunction

    function void note_block(input logic op, input logic [31:0] hi, input logic [31:0] lo,
                             output logic [31:0] res_hi, output logic [31:0] res_lo);
      cipher_txn_t t;
      t.op    = op;
      t.in_hi = hi;
      t.in_lo = lo;
      cipher_block(op, hi, lo, t.res_hi, t.res_lo);
      expected_blocks.push_back(t);
      res_hi = t.res_hi;
      res_lo = t.res_lo;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_block(logic [31:0] hi, logic [31:0] lo);
      cipher_txn_t t;
      if (expected_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected result %08h_%08h", hi, lo));
        return;
      end
      t = expected_blocks.pop_front();
      if (hi !== t.res_hi)
        report_mismatch($sformatf("op %0b in %08h_%08h: result_high %08h, want %08h",
                                  t.op, t.in_hi, t.in_lo, hi, t.res_hi));
      if (lo !== t.res_lo)
        report_mismatch($sformatf("op %0b in %08h_%08h: result_low %08h, want %08h",
                                  t.op, t.in_hi, t.in_lo, lo, t.res_lo));
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [speck_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [speck_pkg::WORD_W-1:0]    cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_operation;
  logic [speck_pkg::WORD_W-1:0]    in_block_high;
  logic [speck_pkg::WORD_W-1:0]    in_block_low;
  logic                            out_valid;
  logic                            out_ready;
  logic [speck_pkg::WORD_W-1:0]    out_result_high;
  logic [speck_pkg::WORD_W-1:0]    out_result_low;

  cipher_scoreboard sb;
  bit               calm;      // no gaps and no stalls while set
  logic             echo_op;   // last accepted transaction and its predicted result,
  logic [31:0]      echo_hi;   // fed back the other way round for round trips
  logic [31:0]      echo_lo;
  bit               echo_ok;

  speck64_128_block_cipher_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_high (out_result_high),
    .out_result_low  (out_result_low)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run (~1400 transactions, each
  // with a long gap, the full round latency and a long output stall).
  initial begin
    #(64'd20_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // Field values biased towards the corners; plain random otherwise.
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return 32'h1 << $urandom_range(0, 31);
    if (r == 3) return ~(32'h1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  // Output side: random back-pressure, released throughout calm phases.
  initial begin
    int r;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (calm || r < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        if (r < 95) repeat ($urandom_range(0, 3)) @(negedge clk);
        else repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  // Result monitor, sampled on the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_block(out_result_high, out_result_low);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // in_valid gets only one assignment per edge, so back-to-back stays high.
  task automatic send_block(input logic op, input logic [31:0] hi, input logic [31:0] lo,
                            input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_block_high <= hi;
    in_block_low  <= lo;
    do @(posedge clk); while (!in_ready);
    sb.note_block(op, hi, lo, echo_hi, echo_lo);
    echo_op = op;
    echo_ok = 1'b1;
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding transaction come back.
  task automatic drain_blocks();
    in_valid <= 1'b0;
    while (sb.expected_blocks.size() != 0) @(negedge clk);
  endtask

  // Only called with the block idle. Writes back to back unless spaced is set,
  // in which case the schedule restart is hit part way through.
  task automatic write_key_word(input logic [speck_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] val, input bit spaced);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_key_word(idx, val);
    @(negedge clk);
    if (spaced) begin
      cfg_we <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  endtask

  task automatic write_key(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3, input bit spaced);
    write_key_word(speck_pkg::CFG_KEY0, k0, spaced);
    write_key_word(speck_pkg::CFG_KEY1, k1, spaced);
    write_key_word(speck_pkg::CFG_KEY2, k2, spaced);
    write_key_word(speck_pkg::CFG_KEY3, k3, spaced);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic        op;
    logic [31:0] hi;
    logic [31:0] lo;

    sb            = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = speck_pkg::CFG_KEY0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_operation  = speck_pkg::OP_ENCRYPT;
    in_block_high = '0;
    in_block_low  = '0;
    out_ready     = 1'b0;
    calm          = 1'b1;
    echo_ok       = 1'b0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset key (all-zero expansion): block corners, both directions.
    send_block(speck_pkg::OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 0);
    send_block(speck_pkg::OP_DECRYPT, 32'h0000_0000, 32'h0000_0000, 0);
    send_block(speck_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_block(speck_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_block(speck_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    send_block(speck_pkg::OP_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_block(speck_pkg::OP_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 0);
    send_block(speck_pkg::OP_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 0);
    send_block(speck_pkg::OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 0);
    send_block(speck_pkg::OP_DECRYPT, echo_hi, echo_lo, 0);   // round trip of the one above
    drain_blocks();

    // Published test key; its plaintext forward and its ciphertext backward.
    write_key(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918, 1'b0);
    send_block(speck_pkg::OP_ENCRYPT, 32'h7475_432d, 32'h3b72_6574, 0);
    send_block(speck_pkg::OP_DECRYPT, 32'h454e_028b, 32'h8c6f_a548, 0);
    send_block(speck_pkg::OP_DECRYPT, 32'h7475_432d, 32'h3b72_6574, 0);
    send_block(speck_pkg::OP_ENCRYPT, echo_hi, echo_lo, 0);
    send_block(speck_pkg::OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_block(speck_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    drain_blocks();

    // Random phases, one key setting each: all ones, explicit zeros, random
    // keys, then two-word updates on top of the last key.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_key('1, '1, '1, '1, 1'b0);
        1: write_key('0, '0, '0, '0, 1'b1);
        2, 3: write_key($urandom, $urandom, $urandom, $urandom, p == 3);
        default: begin
          write_key_word(p == 6 ? speck_pkg::CFG_KEY3 : speck_pkg::CFG_KEY0,
                         pick_word(), 1'b0);
          write_key_word(speck_pkg::CFG_KEY1, pick_word(), 1'b1);
          cfg_we <= 1'b0;
        end
      endcase
      calm = (p == 2) || (p == 5);

      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (echo_ok && $urandom_range(0, 4) == 0) begin
          // feed the last result back the other way: should give the input back
          op = (echo_op == speck_pkg::OP_ENCRYPT) ? speck_pkg::OP_DECRYPT
                                                  : speck_pkg::OP_ENCRYPT;
          hi = echo_hi;
          lo = echo_lo;
        end else begin
          op = $urandom_range(0, 1) ? speck_pkg::OP_DECRYPT : speck_pkg::OP_ENCRYPT;
          hi = pick_word();
          lo = pick_word();
        end
        send_block(op, hi, lo, pick_gap());
      end
      drain_blocks();
    end

    // Any stray result in this window is caught by the monitor.
    repeat (2 * ROUNDS) @(negedge clk);
    if (sb.expected_blocks.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_blocks.size()));

    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
